@@ rtl/core/gsq_pkg.sv @@
// Shared types, constants and the sequencer microcode for the 3x3 Gram-Schmidt QR block.
`default_nettype none
package gsq_pkg;

	localparam int DATA_WIDTH = 40;
	localparam int FRAC_BITS  = 24;

	// internal value: signed, clamped to +-2^62
	localparam int VW = 64;
	localparam int MW = VW - 1;
	localparam int AW = 2 * VW;
	localparam int NW = MW + FRAC_BITS + 1;
	localparam int RW = VW + 2;
	localparam int CW = $clog2(NW + 1);

	localparam int RF_DEPTH = 32;
	localparam int RF_AW    = $clog2(RF_DEPTH);
	localparam int PC_W     = 7;

	typedef logic signed [VW-1:0] val_t;
	typedef logic [RF_AW-1:0] raddr_t;

	localparam val_t ILIM    = {2'b01, {(VW-2){1'b0}}};
	localparam val_t FX_ONE  = {{(VW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam val_t OUT_MAX = {{(VW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam val_t OUT_MIN = ~OUT_MAX;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] a_r0_c0;
		logic signed [DATA_WIDTH-1:0] a_r1_c0;
		logic signed [DATA_WIDTH-1:0] a_r2_c0;
		logic signed [DATA_WIDTH-1:0] a_r0_c1;
		logic signed [DATA_WIDTH-1:0] a_r1_c1;
		logic signed [DATA_WIDTH-1:0] a_r2_c1;
		logic signed [DATA_WIDTH-1:0] a_r0_c2;
		logic signed [DATA_WIDTH-1:0] a_r1_c2;
		logic signed [DATA_WIDTH-1:0] a_r2_c2;
	} mat_t;

	typedef struct packed {
		logic [1:0]                   column_index;
		logic signed [DATA_WIDTH-1:0] q_row0;
		logic signed [DATA_WIDTH-1:0] q_row1;
		logic signed [DATA_WIDTH-1:0] q_row2;
		logic signed [DATA_WIDTH-1:0] r_row0;
		logic signed [DATA_WIDTH-1:0] r_row1;
		logic signed [DATA_WIDTH-1:0] r_row2;
		logic signed [DATA_WIDTH-1:0] m_row0;
		logic signed [DATA_WIDTH-1:0] m_row1;
		logic signed [DATA_WIDTH-1:0] m_row2;
		logic                         last_column;
	} col_t;

	typedef enum logic [2:0] {
		OP_LDIN,
		OP_LDONE,
		OP_MAC,
		OP_SUB,
		OP_DIV,
		OP_SQRT,
		OP_END
	} op_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_FETCH,
		SQ_ISSUE,
		SQ_WAIT
	} seq_state_t;

	typedef struct packed {
		op_t    op;
		raddr_t a;
		raddr_t b;
		raddr_t dst;
		logic   clr;
		logic   wr;
		logic   neg;
	} uop_t;

	typedef struct packed {
		op_t  op;
		logic clr;
		logic neg;
	} arith_req_t;

	// register file map
	localparam raddr_t A_R01 = 5'd18;
	localparam raddr_t A_R02 = 5'd19;
	localparam raddr_t A_R12 = 5'd20;
	localparam raddr_t A_R00 = 5'd21;
	localparam raddr_t A_R11 = 5'd22;
	localparam raddr_t A_R22 = 5'd23;
	localparam raddr_t A_M00 = 5'd24;
	localparam raddr_t A_M11 = 5'd25;
	localparam raddr_t A_M22 = 5'd26;
	localparam raddr_t A_M01 = 5'd27;
	localparam raddr_t A_M12 = 5'd28;
	localparam raddr_t A_M02 = 5'd29;
	localparam raddr_t A_TMP = 5'd30;
	localparam raddr_t A_ONE = 5'd31;
	localparam raddr_t A_NIL = 5'd0;

	// working column vector v, entry i of column k
	function automatic raddr_t av(input int k, input int i);
		return RF_AW'(3 * k + i);
	endfunction

	// Q entry row i column k
	function automatic raddr_t aq(input int i, input int k);
		return RF_AW'(9 + 3 * k + i);
	endfunction

	function automatic uop_t mk(input op_t op, input raddr_t a, input raddr_t b,
			input raddr_t d, input logic clr, input logic wr, input logic neg);
		uop_t u;
		u.op  = op;
		u.a   = a;
		u.b   = b;
		u.dst = d;
		u.clr = clr;
		u.wr  = wr;
		u.neg = neg;
		return u;
	endfunction

	function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
		uop_t u;
		u = mk(OP_END, A_NIL, A_NIL, A_NIL, 1'b0, 1'b0, 1'b0);
		unique case (pc)
			7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8:
				u = mk(OP_LDIN, pc[RF_AW-1:0], A_NIL, pc[RF_AW-1:0], 1'b0, 1'b1, 1'b0);
			7'd9:  u = mk(OP_LDONE, A_NIL, A_NIL, A_ONE, 1'b0, 1'b1, 1'b0);
			// column 0
			7'd10: u = mk(OP_MAC, av(0,0), av(0,0), A_NIL, 1'b1, 1'b0, 1'b0);
			7'd11: u = mk(OP_MAC, av(0,1), av(0,1), A_NIL, 1'b0, 1'b0, 1'b0);
			7'd12: u = mk(OP_MAC, av(0,2), av(0,2), A_NIL, 1'b0, 1'b0, 1'b0);
			7'd13: u = mk(OP_SQRT, A_NIL, A_NIL, A_R00, 1'b0, 1'b1, 1'b0);
			7'd14: u = mk(OP_DIV, av(0,0), A_R00, aq(0,0), 1'b0, 1'b1, 1'b0);
			7'd15: u = mk(OP_DIV, av(0,1), A_R00, aq(1,0), 1'b0, 1'b1, 1'b0);
			7'd16: u = mk(OP_DIV, av(0,2), A_R00, aq(2,0), 1'b0, 1'b1, 1'b0);
			// column 1
			7'd17: u = mk(OP_MAC, aq(0,0), av(1,0), A_NIL, 1'b1, 1'b0, 1'b0);
			7'd18: u = mk(OP_MAC, aq(1,0), av(1,1), A_NIL, 1'b0, 1'b0, 1'b0);
			7'd19: u = mk(OP_MAC, aq(2,0), av(1,2), A_R01, 1'b0, 1'b1, 1'b0);
			7'd20: u = mk(OP_MAC, A_R01, aq(0,0), A_TMP, 1'b1, 1'b1, 1'b0);
			7'd21: u = mk(OP_SUB, av(1,0), A_TMP, av(1,0), 1'b0, 1'b1, 1'b0);
			7'd22: u = mk(OP_MAC, A_R01, aq(1,0), A_TMP, 1'b1, 1'b1, 1'b0);
			7'd23: u = mk(OP_SUB, av(1,1), A_TMP, av(1,1), 1'b0, 1'b1, 1'b0);
			7'd24: u = mk(OP_MAC, A_R01, aq(2,0), A_TMP, 1'b1, 1'b1, 1'b0);
			7'd25: u = mk(OP_SUB, av(1,2), A_TMP, av(1,2), 1'b0, 1'b1, 1'b0);
			7'd26: u = mk(OP_MAC, av(1,0), av(1,0), A_NIL, 1'b1, 1'b0, 1'b0);
			7'd27: u = mk(OP_MAC, av(1,1), av(1,1), A_NIL, 1'b0, 1'b0, 1'b0);
			7'd28: u = mk(OP_MAC, av(1,2), av(1,2), A_NIL, 1'b0, 1'b0, 1'b0);
			7'd29: u = mk(OP_SQRT, A_NIL, A_NIL, A_R11, 1'b0, 1'b1, 1'b0);
			7'd30: u = mk(OP_DIV, av(1,0), A_R11, aq(0,1), 1'b0, 1'b1, 1'b0);
			7'd31: u = mk(OP_DIV, av(1,1), A_R11, aq(1,1), 1'b0, 1'b1, 1'b0);
			7'd32: u = mk(OP_DIV, av(1,2), A_R11, aq(2,1), 1'b0, 1'b1, 1'b0);
			// column 2, against Q column 0
			7'd33: u = mk(OP_MAC, aq(0,0), av(2,0), A_NIL, 1'b1, 1'b0, 1'b0);
			7'd34: u = mk(OP_MAC, aq(1,0), av(2,1), A_NIL, 1'b0, 1'b0, 1'b0);
			7'd35: u = mk(OP_MAC, aq(2,0), av(2,2), A_R02, 1'b0, 1'b1, 1'b0);
			7'd36: u = mk(OP_MAC, A_R02, aq(0,0), A_TMP, 1'b1, 1'b1, 1'b0);
			7'd37: u = mk(OP_SUB, av(2,0), A_TMP, av(2,0), 1'b0, 1'b1, 1'b0);
			7'd38: u = mk(OP_MAC, A_R02, aq(1,0), A_TMP, 1'b1, 1'b1, 1'b0);
			7'd39: u = mk(OP_SUB, av(2,1), A_TMP, av(2,1), 1'b0, 1'b1, 1'b0);
			7'd40: u = mk(OP_MAC, A_R02, aq(2,0), A_TMP, 1'b1, 1'b1, 1'b0);
			7'd41: u = mk(OP_SUB, av(2,2), A_TMP, av(2,2), 1'b0, 1'b1, 1'b0);
			// column 2, against Q column 1
			7'd42: u = mk(OP_MAC, aq(0,1), av(2,0), A_NIL, 1'b1, 1'b0, 1'b0);
			7'd43: u = mk(OP_MAC, aq(1,1), av(2,1), A_NIL, 1'b0, 1'b0, 1'b0);
			7'd44: u = mk(OP_MAC, aq(2,1), av(2,2), A_R12, 1'b0, 1'b1, 1'b0);
			7'd45: u = mk(OP_MAC, A_R12, aq(0,1), A_TMP, 1'b1, 1'b1, 1'b0);
			7'd46: u = mk(OP_SUB, av(2,0), A_TMP, av(2,0), 1'b0, 1'b1, 1'b0);
			7'd47: u = mk(OP_MAC, A_R12, aq(1,1), A_TMP, 1'b1, 1'b1, 1'b0);
			7'd48: u = mk(OP_SUB, av(2,1), A_TMP, av(2,1), 1'b0, 1'b1, 1'b0);
			7'd49: u = mk(OP_MAC, A_R12, aq(2,1), A_TMP, 1'b1, 1'b1, 1'b0);
			7'd50: u = mk(OP_SUB, av(2,2), A_TMP, av(2,2), 1'b0, 1'b1, 1'b0);
			7'd51: u = mk(OP_MAC, av(2,0), av(2,0), A_NIL, 1'b1, 1'b0, 1'b0);
			7'd52: u = mk(OP_MAC, av(2,1), av(2,1), A_NIL, 1'b0, 1'b0, 1'b0);
			7'd53: u = mk(OP_MAC, av(2,2), av(2,2), A_NIL, 1'b0, 1'b0, 1'b0);
			7'd54: u = mk(OP_SQRT, A_NIL, A_NIL, A_R22, 1'b0, 1'b1, 1'b0);
			7'd55: u = mk(OP_DIV, av(2,0), A_R22, aq(0,2), 1'b0, 1'b1, 1'b0);
			7'd56: u = mk(OP_DIV, av(2,1), A_R22, aq(1,2), 1'b0, 1'b1, 1'b0);
			7'd57: u = mk(OP_DIV, av(2,2), A_R22, aq(2,2), 1'b0, 1'b1, 1'b0);
			// inverse of R by back-substitution
			7'd58: u = mk(OP_DIV, A_ONE, A_R00, A_M00, 1'b0, 1'b1, 1'b0);
			7'd59: u = mk(OP_DIV, A_ONE, A_R11, A_M11, 1'b0, 1'b1, 1'b0);
			7'd60: u = mk(OP_DIV, A_ONE, A_R22, A_M22, 1'b0, 1'b1, 1'b0);
			7'd61: u = mk(OP_MAC, A_M11, A_R12, A_TMP, 1'b1, 1'b1, 1'b0);
			7'd62: u = mk(OP_MAC, A_TMP, A_M22, A_M12, 1'b1, 1'b1, 1'b1);
			7'd63: u = mk(OP_MAC, A_M00, A_R01, A_TMP, 1'b1, 1'b1, 1'b0);
			7'd64: u = mk(OP_MAC, A_TMP, A_M11, A_M01, 1'b1, 1'b1, 1'b1);
			7'd65: u = mk(OP_MAC, A_R01, A_M12, A_NIL, 1'b1, 1'b0, 1'b0);
			7'd66: u = mk(OP_MAC, A_R02, A_M22, A_TMP, 1'b0, 1'b1, 1'b0);
			7'd67: u = mk(OP_MAC, A_M00, A_TMP, A_M02, 1'b1, 1'b1, 1'b1);
			default: u = mk(OP_END, A_NIL, A_NIL, A_NIL, 1'b0, 1'b0, 1'b0);
		endcase
		return u;
	endfunction

	function automatic val_t ext_in(input logic signed [DATA_WIDTH-1:0] x);
		val_t v;
		v = VW'(x);
		if (v > ILIM)
			v = ILIM;
		if (v < -ILIM)
			v = -ILIM;
		return v;
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] sat_out(input val_t v);
		val_t s;
		s = v;
		if (s > OUT_MAX)
			s = OUT_MAX;
		if (s < OUT_MIN)
			s = OUT_MIN;
		return s[DATA_WIDTH-1:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/gram_schmidt_qr_3x3_with_inverse.sv @@
// Top level: 3x3 modified Gram-Schmidt QR with inverse of R, one matrix in, three columns out.
// Each matrix gives three column transactions, all computed on the single shared bit-serial unit.
// The input queue takes two further matrices and the result buffer drains while the next computes.
// Reset: arst_n clears the queue, the sequencer and the result buffer; data registers keep no reset.
`default_nettype none
module gram_schmidt_qr_3x3_with_inverse
	import gsq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic mat_valid,
	output logic      mat_ready,
	input  wire mat_t mat,
	output logic      col_valid,
	input  wire logic col_ready,
	output col_t      col
);

	logic head_valid;
	mat_t head;
	logic pop;
	logic out_empty;
	logic out_load;
	col_t c0;
	col_t c1;
	col_t c2;

	gsq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mat_valid  (mat_valid),
		.mat_ready  (mat_ready),
		.mat        (mat),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	gsq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_empty  (out_empty),
		.out_load   (out_load),
		.c0         (c0),
		.c1         (c1),
		.c2         (c2)
	);

	gsq_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.c0        (c0),
		.c1        (c1),
		.c2        (c2),
		.empty     (out_empty),
		.col_valid (col_valid),
		.col_ready (col_ready),
		.col       (col)
	);

endmodule
`default_nettype wire

@@ rtl/core/gsq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gsq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/core/gsq_front.sv @@
// Input side: accepts matrices and holds them in a two-entry queue for the back end.
`default_nettype none
module gsq_front
	import gsq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic mat_valid,
	output logic      mat_ready,
	input  wire mat_t mat,
	output logic      head_valid,
	output mat_t      head,
	input  wire logic pop
);

	mat_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign mat_ready  = (cnt_q != 2'd2);
	assign push       = mat_valid && mat_ready;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= mat;
	end

endmodule
`default_nettype wire

@@ rtl/core/gsq_arith.sv @@
// Shared bit-serial unit: multiply-accumulate, subtract, divide and square root.
`default_nettype none
module gsq_arith
	import gsq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire arith_req_t req,
	input  wire val_t       opa,
	input  wire val_t       opb,
	output logic            done,
	output val_t            res
);

	localparam logic [AW-1:0] RND_HALF =
		{{(AW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
	localparam logic signed [VW:0] LIM_W = {1'b0, ILIM};

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	op_t           op_q;
	logic          neg_q;
	logic          msgn_q;
	val_t          opa_q;
	val_t          opb_q;
	logic [AW-1:0] acc_q;
	logic [AW-1:0] ma_q;
	logic [MW-1:0] mb_q;
	logic [NW-1:0] work_q;
	logic [RW-1:0] rem_q;
	logic [VW-1:0] root_q;

	logic [RW-1:0] div_rem;
	logic          div_ge;
	logic [RW-1:0] sq_rem;
	logic [RW-1:0] sq_trial;
	logic          sq_ge;

	logic [AW-1:0]       acc_mag;
	logic [AW-1:0]       acc_rnd;
	logic [VW-1:0]       mac_mag;
	val_t                mac_v;
	logic [VW-1:0]       div_mag;
	val_t                div_v;
	val_t                sq_v;
	logic signed [VW:0]  diff;
	val_t                sub_v;

	function automatic logic [MW-1:0] magf(input val_t x);
		logic [VW-1:0] t;
		t = x[VW-1] ? -x : x;
		return t[MW-1:0];
	endfunction

	assign done = busy_q && (cnt_q == '0);

	// restoring division and square-root steps
	assign div_rem  = {rem_q[RW-2:0], work_q[NW-1]};
	assign div_ge   = (div_rem >= RW'(mb_q));
	assign sq_rem   = {rem_q[RW-3:0], acc_q[AW-1:AW-2]};
	assign sq_trial = {root_q, 2'b01};
	assign sq_ge    = (sq_rem >= sq_trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			case (req.op)
				OP_MAC:  cnt_q <= CW'(MW);
				OP_DIV:  cnt_q <= CW'(NW);
				OP_SQRT: cnt_q <= CW'(AW / 2);
				default: cnt_q <= '0;
			endcase
		end else if (busy_q) begin
			if (cnt_q == '0)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= req.op;
			neg_q  <= req.neg;
			opa_q  <= opa;
			opb_q  <= opb;
			msgn_q <= opa[VW-1] ^ opb[VW-1];
			rem_q  <= '0;
			root_q <= '0;
			case (req.op)
				OP_MAC: begin
					ma_q <= AW'(magf(opa));
					mb_q <= magf(opb);
					if (req.clr)
						acc_q <= '0;
				end
				OP_DIV: begin
					mb_q   <= magf(opb);
					work_q <= NW'({magf(opa), {FRAC_BITS{1'b0}}}) + NW'(magf(opb) >> 1);
				end
				default: ;
			endcase
		end else if (busy_q && (cnt_q != '0)) begin
			case (op_q)
				OP_MAC: begin
					if (mb_q[0])
						acc_q <= msgn_q ? acc_q - ma_q : acc_q + ma_q;
					ma_q <= ma_q << 1;
					mb_q <= mb_q >> 1;
				end
				OP_DIV: begin
					rem_q  <= div_ge ? div_rem - RW'(mb_q) : div_rem;
					work_q <= {work_q[NW-2:0], div_ge};
				end
				OP_SQRT: begin
					rem_q  <= sq_ge ? sq_rem - sq_trial : sq_rem;
					root_q <= {root_q[VW-2:0], sq_ge};
					acc_q  <= acc_q << 2;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		// round the magnitude half up, clamp, then restore the sign
		acc_mag = acc_q[AW-1] ? -acc_q : acc_q;
		acc_rnd = (acc_mag + RND_HALF) >> FRAC_BITS;
		mac_mag = (acc_rnd > AW'(ILIM)) ? ILIM : acc_rnd[VW-1:0];
		mac_v   = acc_q[AW-1] ? -$signed(mac_mag) : $signed(mac_mag);
		if (neg_q)
			mac_v = -mac_v;

		div_mag = (work_q > NW'(ILIM)) ? ILIM : work_q[VW-1:0];
		div_v   = msgn_q ? -$signed(div_mag) : $signed(div_mag);

		if (root_q == '0)
			sq_v = val_t'(1);
		else if (root_q > ILIM)
			sq_v = ILIM;
		else
			sq_v = $signed(root_q);

		diff = {opa_q[VW-1], opa_q} - {opb_q[VW-1], opb_q};
		if (diff > LIM_W)
			sub_v = ILIM;
		else if (diff < -LIM_W)
			sub_v = -ILIM;
		else
			sub_v = diff[VW-1:0];

		case (op_q)
			OP_MAC:  res = mac_v;
			OP_DIV:  res = div_v;
			OP_SQRT: res = sq_v;
			default: res = sub_v;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/gsq_out.sv @@
// Result buffer: holds the three column transactions of one matrix and drains them in order.
`default_nettype none
module gsq_out
	import gsq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire col_t c0,
	input  wire col_t c1,
	input  wire col_t c2,
	output logic      empty,
	output logic      col_valid,
	input  wire logic col_ready,
	output col_t      col
);

	col_t       buf_q [3];
	logic [1:0] cnt_q;
	logic       take;

	assign empty     = (cnt_q == 2'd0);
	assign col_valid = !empty;
	assign col       = buf_q[0];
	assign take      = col_valid && col_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else if (load)
			cnt_q <= 2'd3;
		else if (take)
			cnt_q <= cnt_q - 2'd1;
	end

	// advance the queue on every taken transaction
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q[0] <= c0;
			buf_q[1] <= c1;
			buf_q[2] <= c2;
		end else if (take) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/gsq_back.sv @@
// Back end: microcoded sequencer over a register file and the shared arithmetic unit.
`default_nettype none
module gsq_back
	import gsq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire mat_t head,
	output logic      pop,
	input  wire logic out_empty,
	output logic      out_load,
	output col_t      c0,
	output col_t      c1,
	output col_t      c2
);

	seq_state_t      state_q;
	seq_state_t      state_nx;
	logic [PC_W-1:0] pc_q;
	uop_t            uop;

	logic       we;
	raddr_t     waddr;
	val_t       wdata;
	logic       start;
	logic       pc_inc;
	logic       pc_clr;
	val_t       rd_a;
	val_t       rd_b;
	logic       ar_done;
	val_t       ar_res;
	arith_req_t req;
	val_t       shadow_q [RF_DEPTH];

	function automatic val_t in_field(input mat_t m, input raddr_t idx);
		val_t v;
		case (idx)
			5'd0:    v = ext_in(m.a_r0_c0);
			5'd1:    v = ext_in(m.a_r1_c0);
			5'd2:    v = ext_in(m.a_r2_c0);
			5'd3:    v = ext_in(m.a_r0_c1);
			5'd4:    v = ext_in(m.a_r1_c1);
			5'd5:    v = ext_in(m.a_r2_c1);
			5'd6:    v = ext_in(m.a_r0_c2);
			5'd7:    v = ext_in(m.a_r1_c2);
			default: v = ext_in(m.a_r2_c2);
		endcase
		return v;
	endfunction

	assign uop    = uop_rom(pc_q);
	assign req.op  = uop.op;
	assign req.clr = uop.clr;
	assign req.neg = uop.neg;

	gsq_ram #(.WIDTH(VW), .DEPTH(RF_DEPTH)) u_rf_a (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (uop.a),
		.rdata (rd_a)
	);

	gsq_ram #(.WIDTH(VW), .DEPTH(RF_DEPTH)) u_rf_b (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (uop.b),
		.rdata (rd_b)
	);

	gsq_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.opa    (rd_a),
		.opb    (rd_b),
		.done   (ar_done),
		.res    (ar_res)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			SQ_IDLE:  if (head_valid) state_nx = SQ_FETCH;
			SQ_FETCH: state_nx = SQ_ISSUE;
			SQ_ISSUE: begin
				unique case (uop.op)
					OP_LDIN, OP_LDONE: state_nx = SQ_FETCH;
					OP_END:            if (out_empty) state_nx = SQ_IDLE;
					default:           state_nx = SQ_WAIT;
				endcase
			end
			SQ_WAIT:  if (ar_done) state_nx = SQ_FETCH;
			default:  state_nx = SQ_IDLE;
		endcase
	end

	always_comb begin
		we       = 1'b0;
		waddr    = uop.dst;
		wdata    = ar_res;
		start    = 1'b0;
		pc_inc   = 1'b0;
		pc_clr   = 1'b0;
		pop      = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			SQ_ISSUE: begin
				unique case (uop.op)
					OP_LDIN: begin
						we     = 1'b1;
						wdata  = in_field(head, uop.a);
						pc_inc = 1'b1;
					end
					OP_LDONE: begin
						we     = 1'b1;
						wdata  = FX_ONE;
						pc_inc = 1'b1;
						pop    = 1'b1;
					end
					OP_END: begin
						out_load = out_empty;
						pc_clr   = out_empty;
					end
					default: start = 1'b1;
				endcase
			end
			SQ_WAIT: begin
				if (ar_done) begin
					we     = (uop.op != OP_MAC) || uop.wr;
					pc_inc = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_nx;
			if (pc_clr)
				pc_q <= '0;
			else if (pc_inc)
				pc_q <= pc_q + PC_W'(1);
		end
	end

	// hold a copy of every written value for the result columns
	always_ff @(posedge clk) begin
		if (we)
			shadow_q[waddr] <= wdata;
	end

	always_comb begin
		c0.column_index = 2'd0;
		c0.q_row0       = sat_out(shadow_q[aq(0,0)]);
		c0.q_row1       = sat_out(shadow_q[aq(1,0)]);
		c0.q_row2       = sat_out(shadow_q[aq(2,0)]);
		c0.r_row0       = sat_out(shadow_q[A_R00]);
		c0.r_row1       = '0;
		c0.r_row2       = '0;
		c0.m_row0       = sat_out(shadow_q[A_M00]);
		c0.m_row1       = '0;
		c0.m_row2       = '0;
		c0.last_column  = 1'b0;

		c1.column_index = 2'd1;
		c1.q_row0       = sat_out(shadow_q[aq(0,1)]);
		c1.q_row1       = sat_out(shadow_q[aq(1,1)]);
		c1.q_row2       = sat_out(shadow_q[aq(2,1)]);
		c1.r_row0       = sat_out(shadow_q[A_R01]);
		c1.r_row1       = sat_out(shadow_q[A_R11]);
		c1.r_row2       = '0;
		c1.m_row0       = sat_out(shadow_q[A_M01]);
		c1.m_row1       = sat_out(shadow_q[A_M11]);
		c1.m_row2       = '0;
		c1.last_column  = 1'b0;

		c2.column_index = 2'd2;
		c2.q_row0       = sat_out(shadow_q[aq(0,2)]);
		c2.q_row1       = sat_out(shadow_q[aq(1,2)]);
		c2.q_row2       = sat_out(shadow_q[aq(2,2)]);
		c2.r_row0       = sat_out(shadow_q[A_R02]);
		c2.r_row1       = sat_out(shadow_q[A_R12]);
		c2.r_row2       = sat_out(shadow_q[A_R22]);
		c2.m_row0       = sat_out(shadow_q[A_M02]);
		c2.m_row1       = sat_out(shadow_q[A_M12]);
		c2.m_row2       = sat_out(shadow_q[A_M22]);
		c2.last_column  = 1'b1;
	end

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ar_done |-> state_q == SQ_WAIT)
		else $error("arithmetic unit finished outside a wait");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_empty && pc_q != '0)
		else $error("result buffer overwritten");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> state_q == SQ_WAIT)
		else $error("arithmetic start not followed by a wait");

endmodule
`default_nettype wire
